[rtl/core/tmr_pkg.sv]
// Shared types, codes and defaults for the timestamp match ring.
package tmr_pkg;

    localparam int TMR_RING_DEPTH  = 16;
    localparam int TMR_QUEUE_DEPTH = 4;

    localparam int STAMP_W     = 32;
    localparam int NS_W        = 8;
    localparam int MAG_W       = STAMP_W + NS_W;
    localparam int LIVE_W      = 4;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 72;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] CMD_CAPTURE = 2'd0;
    localparam logic [1:0] CMD_TX      = 2'd1;
    localparam logic [1:0] CMD_RX      = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_NONE   = 2'd2;
    localparam logic [1:0] STAT_WINDOW = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_TICK_SCALE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_AGE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_MIN      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RX_MIN      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LATENCY = 3'd5;

    localparam logic [NS_W-1:0]    RST_TICK_SCALE  = 8'd12;
    localparam logic [STAMP_W-1:0] RST_MAX_AGE     = 32'd8333333;
    localparam logic [STAMP_W-1:0] RST_MATCH_LIMIT = 32'd10000000;
    localparam logic [STAMP_W-1:0] RST_TX_MIN      = 32'd1000;
    localparam logic [STAMP_W-1:0] RST_RX_MIN      = 32'd10000;
    localparam logic [STAMP_W-1:0] RST_MAX_LATENCY = 32'd1000000;

    typedef enum logic [1:0] {
        OP_CAPTURE = 2'd0,
        OP_TX      = 2'd1,
        OP_RX      = 2'd2
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [STAMP_W-1:0] counter;
    } item_t;

endpackage

[rtl/core/tmr_front.sv]
// Input stage: accepts stream transfers, decodes the command, drops unused codes.
module tmr_front
    import tmr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    output logic                 push_valid,
    input  logic                 push_ready,
    output item_t                push_item
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;
    item_t hold_item_next;
    logic  accept;
    logic  cmd_known;
    op_t   cmd_op;

    always_comb
    begin
        cmd_known = 1'b1;
        cmd_op    = OP_CAPTURE;
        case (s_axis_tuser)
            CMD_CAPTURE: cmd_op = OP_CAPTURE;
            CMD_TX:      cmd_op = OP_TX;
            CMD_RX:      cmd_op = OP_RX;
            default:     cmd_known = 1'b0;
        endcase
    end

    assign s_axis_tready = !hold_valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_valid    = hold_valid_reg;
    assign push_item     = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg && !push_ready;
        hold_item_next  = hold_item_reg;
        if (accept && cmd_known)
        begin
            hold_valid_next        = 1'b1;
            hold_item_next.op      = cmd_op;
            hold_item_next.counter = s_axis_tdata[STAMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_item_reg <= hold_item_next;
    end

endmodule

[rtl/core/tmr_queue.sv]
// Small FIFO of decoded items between the input stage and the ring engine.
module tmr_queue
    import tmr_pkg::*;
#(
    parameter int DEPTH = TMR_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (fill_reg != CNT_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_item  = slots[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/core/tmr_back.sv]
// Ring engine: stamp memory, config registers, aging walk, match scan and result register.
module tmr_back
    import tmr_pkg::*;
#(
    parameter int RING_DEPTH = TMR_RING_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  item_t                  q_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [1:0]             m_axis_tuser
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int SAT_W = (PTR_W > LIVE_W) ? PTR_W : LIVE_W;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_AGE_RD  = 6'b000010,
        ST_AGE_CHK = 6'b000100,
        ST_SETUP   = 6'b001000,
        ST_SCAN    = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    logic [STAMP_W-1:0] mem [RING_DEPTH];
    logic [STAMP_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]   rd_addr;
    logic               mem_we;

    state_t             state_reg;
    state_t             state_next;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [PTR_W-1:0]   rp_reg;
    logic [PTR_W-1:0]   rp_next;
    logic [STAMP_W-1:0] cnt_reg;
    logic [STAMP_W-1:0] cnt_next;
    logic               rx_reg;
    logic               rx_next;
    logic [PTR_W-1:0]   remain_reg;
    logic [PTR_W-1:0]   remain_next;
    logic [PTR_W-1:0]   scan_addr_reg;
    logic [PTR_W-1:0]   scan_addr_next;
    logic [LIVE_W-1:0]  live_reg;
    logic [LIVE_W-1:0]  live_next;
    logic               found_reg;
    logic               found_next;
    logic [MAG_W-1:0]   best_reg;
    logic [MAG_W-1:0]   best_next;
    logic [STAMP_W-1:0] best_ctr_reg;
    logic [STAMP_W-1:0] best_ctr_next;

    logic               p1_reg;
    logic               p1_next;
    logic               p2_reg;
    logic               p3_reg;
    logic [STAMP_W-1:0] ticks2_reg;
    logic               pos2_reg;
    logic [STAMP_W-1:0] ts2_reg;
    logic [MAG_W-1:0]   mag3_reg;
    logic               pos3_reg;
    logic [STAMP_W-1:0] ts3_reg;
    logic               pos1;
    logic [STAMP_W-1:0] ticks1;
    logic               take3;

    logic [NS_W-1:0]    tick_scale_reg;
    logic [STAMP_W-1:0] max_age_reg;
    logic [STAMP_W-1:0] match_limit_reg;
    logic [STAMP_W-1:0] tx_min_reg;
    logic [STAMP_W-1:0] rx_min_reg;
    logic [STAMP_W-1:0] max_latency_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         out_status_reg;
    logic [STAMP_W-1:0] out_latency_reg;
    logic [STAMP_W-1:0] out_ctr_reg;
    logic [LIVE_W-1:0]  out_live_reg;
    logic               out_load;

    logic [PTR_W-1:0]   wp_inc;
    logic [PTR_W-1:0]   rp_inc;
    logic [PTR_W-1:0]   wp_dec;
    logic [PTR_W:0]     count_wide;
    logic [PTR_W-1:0]   count;
    logic [SAT_W-1:0]   count_sat;
    logic [STAMP_W-1:0] age_ticks;
    logic [STAMP_W-1:0] win_lo;
    logic [1:0]         status;

    assign cfg_ready = 1'b1;

    assign wp_inc = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign wp_dec = (wp_reg == '0) ? PTR_W'(RING_DEPTH - 1) : wp_reg - 1'b1;

    assign count_wide = {1'b0, wp_reg} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rp_reg};
    assign count      = (wp_reg >= rp_reg) ? (wp_reg - rp_reg) : count_wide[PTR_W-1:0];
    assign count_sat  = SAT_W'(count);
    assign age_ticks  = rd_data_reg - cnt_reg;

    assign pos1   = (rd_data_reg >= cnt_reg);
    assign ticks1 = pos1 ? (rd_data_reg - cnt_reg) : (cnt_reg - rd_data_reg);

    // newest-first scan, strict compare keeps the newer entry on ties
    assign take3 = p3_reg && (mag3_reg != '0) && (pos3_reg == rx_reg)
                   && (mag3_reg < {{NS_W{1'b0}}, match_limit_reg})
                   && (!found_reg || (mag3_reg < best_reg));

    assign win_lo = rx_reg ? rx_min_reg : tx_min_reg;

    always_comb
    begin
        if (live_reg == '0)
        begin
            status = STAT_EMPTY;
        end
        else if (!found_reg)
        begin
            status = STAT_NONE;
        end
        else if ((best_reg >= {{NS_W{1'b0}}, win_lo})
                 && (best_reg < {{NS_W{1'b0}}, max_latency_reg}))
        begin
            status = STAT_OK;
        end
        else
        begin
            status = STAT_WINDOW;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        cnt_next       = cnt_reg;
        rx_next        = rx_reg;
        remain_next    = remain_reg;
        scan_addr_next = scan_addr_reg;
        live_next      = live_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_ctr_next  = best_ctr_reg;
        p1_next        = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = rp_reg;
        q_ready        = 1'b0;
        out_load       = 1'b0;

        if (take3)
        begin
            found_next    = 1'b1;
            best_next     = mag3_reg;
            best_ctr_next = ts3_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    if (q_item.op == OP_CAPTURE)
                    begin
                        mem_we  = 1'b1;
                        wp_next = wp_inc;
                        if (wp_inc == rp_reg)
                        begin
                            rp_next = rp_inc;
                        end
                    end
                    else
                    begin
                        cnt_next   = q_item.counter;
                        rx_next    = (q_item.op == OP_RX);
                        state_next = ST_AGE_RD;
                    end
                end
            end
            ST_AGE_RD:
            begin
                if (rp_reg == wp_reg)
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_AGE_CHK;
                end
            end
            ST_AGE_CHK:
            begin
                // ticks compare stands for the ns compare when tick_scale is nonzero
                if ((tick_scale_reg != '0) && (age_ticks > max_age_reg))
                begin
                    rp_next    = rp_inc;
                    state_next = ST_AGE_RD;
                end
                else
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                remain_next    = count;
                scan_addr_next = wp_dec;
                live_next      = (count_sat > SAT_W'(15)) ? LIVE_W'(15) : count_sat[LIVE_W-1:0];
                found_next     = 1'b0;
                best_next      = '0;
                best_ctr_next  = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (remain_reg != '0)
                begin
                    rd_addr        = scan_addr_reg;
                    p1_next        = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    scan_addr_next = (scan_addr_reg == '0) ? PTR_W'(RING_DEPTH - 1)
                                                           : scan_addr_reg - 1'b1;
                end
                else if (!p1_reg && !p2_reg && !p3_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            p3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            p1_reg        <= p1_next;
            p2_reg        <= p1_reg;
            p3_reg        <= p2_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_scale_reg  <= RST_TICK_SCALE;
            max_age_reg     <= RST_MAX_AGE;
            match_limit_reg <= RST_MATCH_LIMIT;
            tx_min_reg      <= RST_TX_MIN;
            rx_min_reg      <= RST_RX_MIN;
            max_latency_reg <= RST_MAX_LATENCY;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TICK_SCALE:  tick_scale_reg  <= cfg_data[NS_W-1:0];
                REG_MAX_AGE:     max_age_reg     <= cfg_data[STAMP_W-1:0];
                REG_MATCH_LIMIT: match_limit_reg <= cfg_data[STAMP_W-1:0];
                REG_TX_MIN:      tx_min_reg      <= cfg_data[STAMP_W-1:0];
                REG_RX_MIN:      rx_min_reg      <= cfg_data[STAMP_W-1:0];
                REG_MAX_LATENCY: max_latency_reg <= cfg_data[STAMP_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= q_item.counter;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        rx_reg        <= rx_next;
        remain_reg    <= remain_next;
        scan_addr_reg <= scan_addr_next;
        live_reg      <= live_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        best_ctr_reg  <= best_ctr_next;
        ticks2_reg    <= ticks1;
        pos2_reg      <= pos1;
        ts2_reg       <= rd_data_reg;
        mag3_reg      <= MAG_W'(ticks2_reg) * MAG_W'(tick_scale_reg);
        pos3_reg      <= pos2_reg;
        ts3_reg       <= ts2_reg;
        if (out_load)
        begin
            out_status_reg  <= status;
            out_latency_reg <= best_reg[STAMP_W-1:0];
            out_ctr_reg     <= best_ctr_reg;
            out_live_reg    <= live_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - 2 * STAMP_W - LIVE_W)'(0),
                            out_live_reg, out_ctr_reg, out_latency_reg};

endmodule

[rtl/core/timestamp_match_ring.sv]
// Top level of the timestamp match ring.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: counter; tuser: cmd
//  m_axis    out  m_axis_tvalid/tready      tdata: latency, matched_counter,
//                                           live_entries; tuser: status
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  A capture is written straight from idle. A query ages out stale entries from the
//  oldest end, then scans the live entries newest first through the single read port
//  of the stamp memory and the 4-stage scan pipeline; its result waits while an
//  earlier result is still stalled on m_axis.
//  Reset clears the pointers; no clearing pass.
//  The input queue keeps taking items, until it is full, while a query runs or a result waits.
module timestamp_match_ring
    import tmr_pkg::*;
#(
    parameter int RING_DEPTH  = TMR_RING_DEPTH,
    parameter int QUEUE_DEPTH = TMR_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [31:0] counter
    input  logic [1:0]             s_axis_tuser,   // [1:0] cmd
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [31:0] latency, [63:32]
                                                   // matched_counter, [67:64] live_entries
    output logic [1:0]             m_axis_tuser,   // [1:0] status
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    tmr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    tmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    tmr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[rtl/core/tmr_checker.sv]
// Port-level checks on the result stream, bound to the top level.
module tmr_checker
    import tmr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_EMPTY)
        |-> (m_axis_tdata[2*STAMP_W+LIVE_W-1:0] == '0))
        else $error("empty ring result carries data");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_NONE)
        |-> (m_axis_tdata[2*STAMP_W-1:0] == '0)
            && (m_axis_tdata[2*STAMP_W+LIVE_W-1:2*STAMP_W] != '0))
        else $error("no-candidate result inconsistent");

    a_match_live: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == STAT_OK) || (m_axis_tuser == STAT_WINDOW))
        |-> (m_axis_tdata[STAMP_W-1:0] != '0)
            && (m_axis_tdata[2*STAMP_W+LIVE_W-1:2*STAMP_W] != '0))
        else $error("match reported with zero latency or empty ring");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:2*STAMP_W+LIVE_W] == '0))
        else $error("tdata padding not zero");

endmodule

bind timestamp_match_ring tmr_checker u_tmr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_timestamp_match_ring.sv]
// Self-checking testbench for timestamp_match_ring: directed and random stream traffic against a ring predictor.
module tb_timestamp_match_ring;
    timeunit 1ns;
    timeprecision 1ps;
    import tmr_pkg::*;

    localparam int RING          = TMR_RING_DEPTH;
    localparam int SETTLE_CYCLES = 300;

    localparam logic [1:0]             CMD_RESERVED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B  = 3'd7;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [STAMP_W-1:0] counter;
    } stamp_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        latency;
        logic [STAMP_W-1:0] matched_counter;
        logic [LIVE_W-1:0]  live_entries;
    } match_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    stamp_item_t   stamp_stream[$];
    match_report_t expected_reports[$];
    stamp_item_t   next_item;
    int            src_idle_pct = 17;
    int            sink_idle_pct = 17;
    int            error_count = 0;

    // predictor state
    logic [STAMP_W-1:0] stamp_ring [RING];
    int                 wr_ptr = 0;
    int                 rd_ptr = 0;
    logic [NS_W-1:0]    cfg_tick_scale = RST_TICK_SCALE;
    logic [31:0]        cfg_max_age = RST_MAX_AGE;
    logic [31:0]        cfg_match_limit = RST_MATCH_LIMIT;
    logic [31:0]        cfg_tx_min = RST_TX_MIN;
    logic [31:0]        cfg_rx_min = RST_RX_MIN;
    logic [31:0]        cfg_max_latency = RST_MAX_LATENCY;

    timestamp_match_ring u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // wrapped tick distance a - b scaled to ns at full width
    function automatic logic [63:0] span_ns(logic [31:0] a, logic [31:0] b);
        logic [31:0] ticks;
        ticks = a - b;
        return {32'd0, ticks} * {56'd0, cfg_tick_scale};
    endfunction

    function automatic void advance_ring(logic [1:0] cmd, logic [31:0] cnt);
        logic [63:0]   age_limit;
        logic [63:0]   mag;
        logic [63:0]   best_mag;
        logic [63:0]   low_bound;
        logic [31:0]   ts;
        logic [31:0]   best_ts;
        logic          rx;
        logic          found;
        logic          positive;
        int            count;
        int            idx;
        match_report_t rep;
        if (cmd == CMD_CAPTURE)
        begin
            stamp_ring[wr_ptr] = cnt;
            wr_ptr = (wr_ptr + 1) % RING;
            if (wr_ptr == rd_ptr)
                rd_ptr = (rd_ptr + 1) % RING;
            return;
        end
        if (cmd == CMD_RESERVED)
            return;
        rx = (cmd == CMD_RX);
        found = 1'b0;
        best_mag = '0;
        best_ts = '0;
        age_limit = {32'd0, cfg_max_age} * {56'd0, cfg_tick_scale};
        while (rd_ptr != wr_ptr && span_ns(stamp_ring[rd_ptr], cnt) > age_limit)
            rd_ptr = (rd_ptr + 1) % RING;
        count = (wr_ptr + RING - rd_ptr) % RING;
        // newest first; strict compare keeps the newer entry on a tie
        for (int i = 0; i < count; i++)
        begin
            idx = (wr_ptr + 2 * RING - 1 - i) % RING;
            ts = stamp_ring[idx];
            positive = (ts >= cnt);
            mag = positive ? span_ns(ts, cnt) : span_ns(cnt, ts);
            if (mag != 0 && rx == positive && mag < {32'd0, cfg_match_limit}
                && (!found || mag < best_mag))
            begin
                best_mag = mag;
                best_ts = ts;
                found = 1'b1;
            end
        end
        low_bound = {32'd0, (rx ? cfg_rx_min : cfg_tx_min)};
        if (count == 0)
            rep.status = STAT_EMPTY;
        else if (!found)
            rep.status = STAT_NONE;
        else if (best_mag >= low_bound && best_mag < {32'd0, cfg_max_latency})
            rep.status = STAT_OK;
        else
            rep.status = STAT_WINDOW;
        rep.latency = found ? best_mag[31:0] : 32'd0;
        rep.matched_counter = found ? best_ts : 32'd0;
        rep.live_entries = (count > 15) ? LIVE_W'(15) : LIVE_W'(count);
        expected_reports.push_back(rep);
    endfunction

    function automatic void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        case (idx)
            REG_TICK_SCALE:  cfg_tick_scale = val[NS_W-1:0];
            REG_MAX_AGE:     cfg_max_age = val;
            REG_MATCH_LIMIT: cfg_match_limit = val;
            REG_TX_MIN:      cfg_tx_min = val;
            REG_RX_MIN:      cfg_rx_min = val;
            REG_MAX_LATENCY: cfg_max_latency = val;
            default: ;
        endcase
    endfunction

    function automatic void check_report();
        match_report_t want;
        if (expected_reports.size() == 0)
        begin
            $error("unexpected result: status %0d latency %0d matched_counter %h",
                   m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
            error_count++;
            return;
        end
        want = expected_reports.pop_front();
        if (m_axis_tuser !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            error_count++;
        end
        if (m_axis_tdata[31:0] !== want.latency)
        begin
            $error("latency: expected %0d, actual %0d", want.latency,
                   m_axis_tdata[31:0]);
            error_count++;
        end
        if (m_axis_tdata[63:32] !== want.matched_counter)
        begin
            $error("matched_counter: expected %h, actual %h", want.matched_counter,
                   m_axis_tdata[63:32]);
            error_count++;
        end
        if (m_axis_tdata[67:64] !== want.live_entries)
        begin
            $error("live_entries: expected %0d, actual %0d", want.live_entries,
                   m_axis_tdata[67:64]);
            error_count++;
        end
    endfunction

    function automatic void push_item(logic [1:0] cmd, logic [31:0] cnt);
        stamp_stream.push_back('{cmd, cnt});
    endfunction

    function automatic logic [31:0] pick_span();
        case ($urandom_range(5))
            0:       return $urandom_range(3);
            1:       return $urandom_range(300);
            2:       return $urandom_range(30000);
            3:       return $urandom_range(3000000);
            4:       return $urandom_range(20000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] jitter();
        logic [31:0] span;
        span = pick_span();
        return $urandom_range(1) ? span : -span;
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(3))
            0:       return $urandom_range(100000);
            1:       return 32'hFFFF_FFFF - $urandom_range(100000);
            default: return $urandom;
        endcase
    endfunction

    // mostly capture bursts followed by queries near the same counter, some noise
    function automatic void queue_traffic(int n);
        int          made;
        int          caps;
        int          queries;
        logic [31:0] base;
        logic [1:0]  cmd;
        made = 0;
        base = pick_base();
        while (made < n)
        begin
            if ($urandom_range(99) < 12)
            begin
                cmd = 2'($urandom_range(3));
                push_item(cmd, $urandom);
                if (cmd != CMD_RESERVED)
                    made++;
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    base = pick_base();
                else
                    base = base - pick_span();
                caps = $urandom_range(($urandom_range(9) == 0) ? 20 : 4);
                queries = $urandom_range(1, 3);
                for (int i = 0; i < caps; i++)
                    push_item(CMD_CAPTURE, base + jitter());
                for (int i = 0; i < queries; i++)
                    push_item($urandom_range(1) ? CMD_RX : CMD_TX, base + jitter());
                made += caps + queries;
            end
        end
    endfunction

    function automatic void queue_directed();
        logic [31:0] c;
        c = 32'd20_000_000;
        push_item(CMD_TX, 32'hFFFF_FFFF);
        push_item(CMD_RX, 32'd0);
        push_item(CMD_RESERVED, 32'hFFFF_FFFF);
        push_item(CMD_CAPTURE, c);
        push_item(CMD_RX, c - 1000);
        push_item(CMD_RX, c);
        push_item(CMD_TX, c - 500);
        push_item(CMD_CAPTURE, c - 5000);
        push_item(CMD_TX, c - 4900);
        push_item(CMD_RX, c - 4990);
        push_item(CMD_RX, c - 100);
        push_item(CMD_RX, c - 100000);
        push_item(CMD_RX, c - 9_000_000);
        push_item(CMD_CAPTURE, 32'd5);
        push_item(CMD_RX, 32'd0);
        push_item(CMD_TX, 32'hFFFF_FFF0);
        push_item(CMD_CAPTURE, 32'hFFFF_FFFF);
        push_item(CMD_TX, 32'd0);
        push_item(CMD_CAPTURE, 32'hAAAA_AAAA);
        push_item(CMD_CAPTURE, 32'h5555_5555);
        push_item(CMD_TX, 32'hFFFF_FFFF);
        push_item(CMD_RESERVED, 32'd0);
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_reg(idx, val);
    endtask

    task automatic load_regs(logic [7:0] ns, logic [31:0] age, logic [31:0] match_lim,
                             logic [31:0] tx_min, logic [31:0] rx_min,
                             logic [31:0] max_lat);
        write_reg(REG_TICK_SCALE, {24'd0, ns});
        write_reg(REG_MAX_AGE, age);
        write_reg(REG_MATCH_LIMIT, match_lim);
        write_reg(REG_TX_MIN, tx_min);
        write_reg(REG_RX_MIN, rx_min);
        write_reg(REG_MAX_LATENCY, max_lat);
    endtask

    // hold off until every query has reported, then let trailing captures retire
    task automatic drain();
        while (stamp_stream.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_ring(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (stamp_stream.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    next_item = stamp_stream.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_item.cmd;
                    s_axis_tdata  <= next_item.counter;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_report();
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_directed();
        queue_traffic(200);
        drain();

        // widest window; no idling on either side for this stretch
        load_regs(8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        src_idle_pct = 0;
        sink_idle_pct = 0;
        queue_traffic(250);
        drain();
        src_idle_pct = 17;
        sink_idle_pct = 17;

        load_regs(8'd255, 32'd100000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        queue_traffic(150);
        drain();

        load_regs(8'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
        queue_traffic(100);
        drain();

        // zero scale: no aging, every delta is zero
        load_regs(8'd0, $urandom, $urandom, $urandom, $urandom, $urandom);
        queue_traffic(100);
        drain();

        load_regs(8'd255, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        queue_traffic(50);
        drain();

        repeat (4)
        begin
            load_regs(8'($urandom_range(1, 255)), pick_span(), pick_span(),
                      $urandom_range(5000), $urandom_range(50000), pick_span());
            queue_traffic(180);
            drain();
        end

        load_regs(RST_TICK_SCALE, RST_MAX_AGE, RST_MATCH_LIMIT, RST_TX_MIN, RST_RX_MIN,
                  RST_MAX_LATENCY);
        queue_traffic(100);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
